// ===== sv/pcal_pkg.sv =====
// ============================================================================
// pcal_pkg - shared types and constants for the potentiometer range calibrator
// Item kinds, register map, channel types, lane status struct and the
// divide-by-200 helper used by the classifier.
// ============================================================================
`default_nettype none

package pcal_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // register indexes (word address = paddr[3:2])
    localparam logic [1:0] REG_COEF  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_EXP_A = 2'd2;
    localparam logic [1:0] REG_EXP_B = 2'd3;

    // register reset values
    localparam logic [15:0] COEF_RST  = 16'd6553;
    localparam logic [15:0] LIMIT_RST = 16'd4000;

    // channel types
    localparam logic [1:0] TYPE_DISABLED = 2'd0;
    localparam logic [1:0] TYPE_NORMAL   = 2'd1;
    localparam logic [1:0] TYPE_CENTRE   = 2'd2;
    localparam logic [1:0] TYPE_AUTO     = 2'd3;

    // tracker extremes
    localparam logic signed [15:0] TRACK_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TRACK_MIN = 16'sh8000;

    // filter datapath widths
    localparam int D_W    = 21;   // difference term
    localparam int PROD_W = 38;   // difference times unsigned coefficient

    // saturation limits
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // divide by 200: multiply by ceil(2^20/200), exact for magnitudes <= 32768
    localparam logic [12:0] RECIP_200   = 13'd5243;
    localparam int          RECIP_SHIFT = 20;

    // output word width: two channels of 2+1+3*16 bits, padded to bytes
    localparam int OUT_W = 104;

    typedef struct packed {
        logic signed [15:0] low;
        logic signed [15:0] mid;
        logic signed [15:0] high;
    } t_lane_stat;

    // quotient of v / 200, truncated toward zero
    function automatic logic signed [8:0] div200(input logic signed [15:0] v);
        logic [15:0] mag;
        logic [28:0] prod;
        logic [8:0]  q;
        mag  = v[15] ? (~v + 16'd1) : v;
        prod = 29'(mag) * 29'(RECIP_200);
        q    = 9'(prod >> RECIP_SHIFT);
        return v[15] ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

// ===== sv/pcal_lane.sv =====
// ============================================================================
// pcal_lane - one calibration channel
// Q16.16 first-order low-pass with saturation, then centre / min / max
// tracking of the integer part. One step per cycle.
// ============================================================================
`default_nettype none

module pcal_lane #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_seed,
    input  wire logic                   i_step,
    input  wire logic [ADC_BITS-1:0]    i_sample,
    input  wire logic [15:0]            i_coef,
    output pcal_pkg::t_lane_stat        o_stat
);
    import pcal_pkg::*;

    logic signed [31:0]     r_filt, n_filt;
    logic signed [15:0]     r_low, n_low;
    logic signed [15:0]     r_high, n_high;
    logic signed [15:0]     r_mid, n_mid;

    logic signed [D_W-1:0]    w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [33:0]       w_tap;
    logic signed [31:0]       w_tsat;
    logic signed [32:0]       w_sum;
    logic signed [31:0]       w_ynew;
    logic signed [15:0]       w_cen;

    // filter step: d = 16*u - floor(y/4096); t = sat(floor(d*coef/16)); y = sat(y+t)
    always_comb begin
        w_diff = $signed({{(D_W-ADC_BITS-4){1'b0}}, i_sample, 4'b0000})
               - $signed({r_filt[31], r_filt[31:12]});
        w_prod = w_diff * $signed({1'b0, i_coef});
        w_tap  = w_prod[PROD_W-1:4];
        if (w_tap[33:31] == 3'b000 || w_tap[33:31] == 3'b111) begin
            w_tsat = w_tap[31:0];
        end else begin
            w_tsat = w_tap[33] ? SAT_MIN : SAT_MAX;
        end
        w_sum = {r_filt[31], r_filt} + {w_tsat[31], w_tsat};
        if (w_sum[32] == w_sum[31]) begin
            w_ynew = w_sum[31:0];
        end else begin
            w_ynew = w_sum[32] ? SAT_MIN : SAT_MAX;
        end
        w_cen = w_ynew[31:16];
    end

    // next state
    always_comb begin
        n_filt = r_filt;
        n_low  = r_low;
        n_high = r_high;
        n_mid  = r_mid;
        if (i_seed) begin
            n_filt = {{(16-ADC_BITS){1'b0}}, i_sample, 16'h0000};
            n_low  = TRACK_MAX;
            n_high = TRACK_MIN;
            n_mid  = 16'sd0;
        end else if (i_step) begin
            n_filt = w_ynew;
            n_mid  = w_cen;
            if (w_cen < r_low) begin
                n_low = w_cen;
            end
            if (w_cen > r_high) begin
                n_high = w_cen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= 32'sd0;
            r_low  <= TRACK_MAX;
            r_high <= TRACK_MIN;
            r_mid  <= 16'sd0;
        end else begin
            r_filt <= n_filt;
            r_low  <= n_low;
            r_high <= n_high;
            r_mid  <= n_mid;
        end
    end

    assign o_stat.low  = r_low;
    assign o_stat.mid  = r_mid;
    assign o_stat.high = r_high;

endmodule

`default_nettype wire

// ===== sv/pcal_merge.sv =====
// ============================================================================
// pcal_merge - classification and result register
// Classifies both lanes by truncating division by 200, checks each against
// its expected type and packs the result word into the output register.
// ============================================================================
`default_nettype none

module pcal_merge (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire pcal_pkg::t_lane_stat       i_stat_a,
    input  wire pcal_pkg::t_lane_stat       i_stat_b,
    input  wire logic [1:0]                 i_exp_a,
    input  wire logic [1:0]                 i_exp_b,
    input  wire logic                       i_m_tready,
    output logic                            o_take,
    output logic                            o_m_tvalid,
    output logic [pcal_pkg::OUT_W-1:0]      o_m_tdata
);
    import pcal_pkg::*;

    logic                r_valid, n_valid;
    logic [OUT_W-1:0]    r_data;
    logic [1:0]          w_type_a, w_type_b;
    logic                w_ok_a, w_ok_b;
    logic                w_free;

    // raw type of one channel
    function automatic logic [1:0] classify(input t_lane_stat s);
        logic signed [8:0] qmin;
        logic signed [8:0] qmid;
        logic signed [8:0] qmax;
        qmin = div200(s.low);
        qmid = div200(s.mid);
        qmax = div200(s.high);
        if (qmin == qmax || qmid == qmax || s.low > s.high || s.mid > s.high) begin
            return TYPE_DISABLED;
        end
        return (qmin == qmid) ? TYPE_NORMAL : TYPE_CENTRE;
    endfunction

    // check against expected type
    always_comb begin
        w_type_a = classify(i_stat_a);
        w_type_b = classify(i_stat_b);
        w_ok_a   = (w_type_a == i_exp_a) || (i_exp_a == TYPE_AUTO);
        w_ok_b   = (w_type_b == i_exp_b) || (i_exp_b == TYPE_AUTO);
    end

    // output register handshake
    assign w_free = !r_valid || i_m_tready;
    assign o_take = i_valid && w_free;

    always_comb begin
        n_valid = r_valid;
        if (w_free) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, highest field first
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= {2'b00,
                       i_stat_b.high, i_stat_b.mid, i_stat_b.low,
                       w_ok_b, (w_ok_b ? w_type_b : TYPE_DISABLED),
                       i_stat_a.high, i_stat_a.mid, i_stat_a.low,
                       w_ok_a, (w_ok_a ? w_type_a : TYPE_DISABLED)};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

// ===== sv/pot_range_calibrator.sv =====
// ============================================================================
// pot_range_calibrator - two-channel potentiometer range calibration
// Low-pass filters two ADC channels side by side, tracks centre and extremes
// and reports type and acceptance of each channel when calibration ends.
// ============================================================================
// Takes one word per clock while o_s_tready is high. A start word (tuser 0)
// seeds both filters and arms the block; sample words (tuser 1) run one
// filter step per channel; a finish word (tuser 2) or the sample that reaches
// sample_limit emits one result word and disarms. Sample and finish words
// while idle, and tuser 3, are consumed without effect. Each channel lane
// does its saturating multiply-add filter step and min/max update
// combinationally, which sets the rate of one word per cycle; the result
// passes the classifier stage and output registers. Input is held off only
// while a result waits both in the classifier stage and in the output
// register. Registers (APB, 4-byte spaced): 0 filter_coef, 1 sample_limit,
// 2 expected_type_a, 3 expected_type_b; write them only while idle.
// ============================================================================
`default_nettype none

module pot_range_calibrator #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // slave stream
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // [ADC_BITS-1:0] sample_a, [2*ADC_BITS-1:ADC_BITS] sample_b, zero pad
    input  wire logic [((2*ADC_BITS+7)/8)*8-1:0]        i_s_tdata,
    // [1:0] kind
    input  wire logic [1:0]                             i_s_tuser,
    // master stream
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // [1:0] type_a, [2] accepted_a, [18:3] lowest_a, [34:19] centre_a,
    // [50:35] highest_a, [52:51] type_b, [53] accepted_b, [69:54] lowest_b,
    // [85:70] centre_b, [101:86] highest_b, [103:102] zero
    output logic [pcal_pkg::OUT_W-1:0]                  o_m_tdata,
    // configuration
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [3:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import pcal_pkg::*;

    // configuration registers
    logic [15:0]    r_coef;
    logic [15:0]    r_limit;
    logic [1:0]     r_exp_a;
    logic [1:0]     r_exp_b;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= COEF_RST;
            r_limit <= LIMIT_RST;
            r_exp_a <= TYPE_AUTO;
            r_exp_b <= TYPE_AUTO;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_COEF:  r_coef  <= pwdata[15:0];
                REG_LIMIT: r_limit <= pwdata[15:0];
                REG_EXP_A: r_exp_a <= pwdata[1:0];
                REG_EXP_B: r_exp_b <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COEF:  prdata = {16'h0000, r_coef};
            REG_LIMIT: prdata = {16'h0000, r_limit};
            REG_EXP_A: prdata = {30'h0, r_exp_a};
            REG_EXP_B: prdata = {30'h0, r_exp_b};
            default:   prdata = 32'h0;
        endcase
    end

    // sequencing state
    logic           r_running, n_running;
    logic [15:0]    r_samples, n_samples;
    logic           r_emit_v, n_emit_v;
    logic           w_accept;
    logic           w_seed;
    logic           w_step;
    logic           w_emit;
    logic           w_take;
    logic [15:0]    w_count;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_count  = r_samples + 16'd1;

    always_comb begin
        w_seed    = 1'b0;
        w_step    = 1'b0;
        w_emit    = 1'b0;
        n_running = r_running;
        n_samples = r_samples;
        if (w_accept) begin
            case (i_s_tuser)
                KIND_START: begin
                    w_seed    = 1'b1;
                    n_running = 1'b1;
                    n_samples = 16'd0;
                end
                KIND_SAMPLE: begin
                    if (r_running) begin
                        w_step    = 1'b1;
                        n_samples = w_count;
                        if (w_count >= r_limit) begin
                            w_emit    = 1'b1;
                            n_running = 1'b0;
                        end
                    end
                end
                KIND_FINISH: begin
                    if (r_running) begin
                        w_emit    = 1'b1;
                        n_running = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // lane state must not move while a result waits in the classifier stage
    assign o_s_tready = !r_emit_v || w_take;

    always_comb begin
        n_emit_v = r_emit_v;
        if (w_take) begin
            n_emit_v = 1'b0;
        end
        if (w_emit) begin
            n_emit_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_samples <= 16'd0;
            r_emit_v  <= 1'b0;
        end else begin
            r_running <= n_running;
            r_samples <= n_samples;
            r_emit_v  <= n_emit_v;
        end
    end

    // channel lanes
    t_lane_stat     w_stat_a;
    t_lane_stat     w_stat_b;

    pcal_lane #(
        .ADC_BITS   (ADC_BITS)
    ) u_lane_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (w_seed),
        .i_step     (w_step),
        .i_sample   (i_s_tdata[ADC_BITS-1:0]),
        .i_coef     (r_coef),
        .o_stat     (w_stat_a)
    );

    pcal_lane #(
        .ADC_BITS   (ADC_BITS)
    ) u_lane_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (w_seed),
        .i_step     (w_step),
        .i_sample   (i_s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_coef     (r_coef),
        .o_stat     (w_stat_b)
    );

    // classifier and result register
    pcal_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_emit_v),
        .i_stat_a   (w_stat_a),
        .i_stat_b   (w_stat_b),
        .i_exp_a    (r_exp_a),
        .i_exp_b    (r_exp_b),
        .i_m_tready (i_m_tready),
        .o_take     (w_take),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // checks
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_v && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while classifier stage is blocked");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_v |=> o_m_tvalid)
        else $error("classifier result did not reach output register");

    a_emit_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (!r_running && r_emit_v))
        else $error("emitting word left block armed or result lost");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !r_emit_v && !r_running))
        else $error("control state not cleared by reset");

endmodule

`default_nettype wire
